[hw/rtl/b64lw_pkg.sv]
// Package for the line-wrapped Base64 encoder.
// Holds the character constants and the 6-bit to ASCII alphabet mapping.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64lw_pkg;

	localparam int unsigned CharW     = 8;
	localparam int unsigned MaxChars  = 5;
	localparam int unsigned CntW      = $clog2(MaxChars + 1);

	localparam logic [CharW-1:0] CHAR_PAD     = 8'h3D; // '='
	localparam logic [CharW-1:0] CHAR_NL      = 8'h0A;
	localparam logic [CharW-1:0] CHAR_PLUS    = 8'h2B; // '+'
	localparam logic [CharW-1:0] CHAR_SLASH   = 8'h2F; // '/'
	localparam logic [7:0]       GPL_RESET    = 8'd19;

	typedef logic [CharW-1:0] char_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic char_t b64_char(input logic [5:0] idx);
		char_t c;
		if (idx < 6'd26) begin
			c = 8'h41 + {2'b00, idx};
		end else if (idx < 6'd52) begin
			c = 8'h61 + {2'b00, idx} - 8'd26;
		end else if (idx < 6'd62) begin
			c = 8'h30 + {2'b00, idx} - 8'd52;
		end else if (idx == 6'd62) begin
			c = CHAR_PLUS;
		end else begin
			c = CHAR_SLASH;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/base64_line_wrapped_encoder_unit.sv]
// Line-wrapped Base64 encoder: bytes in, ASCII characters out, newline after
// a programmable number of four-character groups. Uses b64lw_pkg.
// The first character of a group is offered in the cycle after the byte
// that completes it (or the last byte) is transferred in.
// Characters go out one per cycle while m_tready is high; a byte that
// yields characters is taken only once the character buffer is empty.
// Bytes that are only held are taken every cycle.
// Reset (arst_n low, asynchronous): buffer empty, no bytes held, line count
// zero, groups_per_line back to 19.
`timescale 1ns / 1ps
`default_nettype none

module base64_line_wrapped_encoder_unit (
	input  wire               clk,
	input  wire               arst_n,
	// input byte stream
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [7:0]        s_tdata,   // [7:0] data_byte
	input  wire               s_tlast,   // last_byte
	// character stream
	output logic              m_tvalid,
	input  wire               m_tready,
	output b64lw_pkg::char_t  m_tdata,   // [7:0] out_char
	output logic              m_tlast,   // run_end
	// groups_per_line register write
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [7:0]        cfg_data
);
	import b64lw_pkg::*;

	logic [7:0]    gpl_q;
	logic [7:0]    held_q [2];
	logic [1:0]    fill_q;
	logic [7:0]    line_cnt_q;

	char_t         chars_q [MaxChars];
	logic [CntW-1:0] cnt_q;

	logic          in_xfer, out_xfer;
	logic          makes_chars;
	char_t         new_chars [MaxChars];
	logic [CntW-1:0] new_cnt;
	logic [8:0]    next_line;
	logic          newline;

	assign cfg_ready   = 1'b1;
	assign makes_chars = (fill_q == 2'd2) || s_tlast;
	assign s_tready    = (cnt_q == '0) || !makes_chars;
	assign in_xfer     = s_tvalid && s_tready;
	assign m_tvalid    = (cnt_q != '0);
	assign m_tdata     = chars_q[0];
	assign m_tlast     = (cnt_q == CntW'(1));
	assign out_xfer    = m_tvalid && m_tready;

	// a zero setting behaves as one, since next_line is at least one
	assign next_line = {1'b0, line_cnt_q} + 9'd1;
	assign newline   = (next_line >= {1'b0, gpl_q});

	always_comb begin
		for (int i = 0; i < MaxChars; i++) begin
			new_chars[i] = CHAR_NL;
		end
		new_cnt = '0;
		if (fill_q == 2'd2) begin
			new_chars[0] = b64_char(held_q[0][7:2]);
			new_chars[1] = b64_char({held_q[0][1:0], held_q[1][7:4]});
			new_chars[2] = b64_char({held_q[1][3:0], s_tdata[7:6]});
			new_chars[3] = b64_char(s_tdata[5:0]);
			new_cnt      = newline ? CntW'(5) : CntW'(4);
		end else if (s_tlast) begin
			new_cnt = CntW'(4);
			if (fill_q == 2'd0) begin
				new_chars[0] = b64_char(s_tdata[7:2]);
				new_chars[1] = b64_char({s_tdata[1:0], 4'b0000});
				new_chars[2] = CHAR_PAD;
				new_chars[3] = CHAR_PAD;
			end else begin
				new_chars[0] = b64_char(held_q[0][7:2]);
				new_chars[1] = b64_char({held_q[0][1:0], s_tdata[7:4]});
				new_chars[2] = b64_char({s_tdata[3:0], 2'b00});
				new_chars[3] = CHAR_PAD;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpl_q      <= GPL_RESET;
			fill_q     <= 2'd0;
			line_cnt_q <= 8'd0;
			cnt_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				gpl_q <= cfg_data;
			end
			if (in_xfer && makes_chars) begin
				cnt_q <= new_cnt;
			end else if (out_xfer) begin
				cnt_q <= cnt_q - CntW'(1);
			end
			if (in_xfer) begin
				if (s_tlast) begin
					fill_q     <= 2'd0;
					line_cnt_q <= 8'd0;
				end else if (fill_q == 2'd2) begin
					fill_q     <= 2'd0;
					line_cnt_q <= newline ? 8'd0 : next_line[7:0];
				end else begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

	// payload: held bytes and character buffer
	always_ff @(posedge clk) begin
		if (in_xfer && !makes_chars) begin
			held_q[fill_q[0]] <= s_tdata;
		end
		if (in_xfer && makes_chars) begin
			chars_q <= new_chars;
		end else if (out_xfer) begin
			for (int i = 0; i < MaxChars - 1; i++) begin
				chars_q[i] <= chars_q[i+1];
			end
		end
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxChars))
		else $error("character count out of range");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("group fill out of range");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_cnt_q != 8'd255)
		else $error("line group count wrapped");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tlast) |=> (fill_q == 2'd0 && line_cnt_q == 8'd0))
		else $error("message end did not clear group state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && makes_chars) |-> (cnt_q == '0))
		else $error("characters loaded over a busy buffer");

	a_group_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && fill_q == 2'd2) |=> (cnt_q == CntW'(4) || cnt_q == CntW'(5)))
		else $error("full group gave wrong character count");

endmodule

`default_nettype wire
